/* rtl/core/sbfs_pkg.sv */
// shared types and constants for the burst sharpness selector
// used by sbfs_ctrl, sbfs_dp and sharpness_best_frame_select_core
package sbfs_pkg;

  localparam int STRIDE_W   = 13;
  localparam int PHASE_W    = 12;
  localparam int BURST_W    = 5;
  localparam int IDX_W      = 4;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 21;
  localparam int SUM_W      = 30;
  localparam int SUM_MAG_W  = 29;
  localparam int SQSUM_W    = 37;
  localparam int SCORE_W    = 24;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  // n * sumsq is split into two partial products over the low and high halves
  localparam int SQ_LO_W  = 19;
  localparam int SQ_HI_W  = SQSUM_W - SQ_LO_W;
  localparam int PLO_W    = COUNT_W + SQ_LO_W;
  localparam int PHI_W    = COUNT_W + SQ_HI_W;
  localparam int DIFF_W   = 58;
  localparam int NN_W     = 2 * COUNT_W;
  localparam int REM_W    = DIFF_W - 16;
  localparam int DIV_STEPS = SCORE_W;
  localparam int DIV_CNT_W = 5;

  localparam logic [STRIDE_W-1:0] STRIDE_CAP   = 13'd4096;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd64;
  localparam logic [BURST_W-1:0]  MAX_BURST    = 5'd16;
  localparam logic [BURST_W-1:0]  BURST_RESET  = 5'd4;
  localparam logic [COUNT_W-1:0]  MAX_SAMPLES  = 21'd1048576;
  localparam logic [SCORE_W-1:0]  SCORE_MAX    = 24'd16646400;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST    = 5'(DIV_STEPS - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STRIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LENGTH  = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul_load;
    logic sub_load;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

/* rtl/core/sbfs_ctrl.sv */
// controller state machine for the burst sharpness selector
// depends on sbfs_pkg; drives the datapath sbfs_dp through dp_cmd_t
module sbfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                frame_end,
  output logic                item_stall,
  output logic                result_valid,
  input  logic                result_stall,
  input  sbfs_pkg::dp_status_t status,
  output sbfs_pkg::dp_cmd_t    cmd
);
  import sbfs_pkg::*;

  state_t state;
  state_t state_next;
  logic   result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    item_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.accept = item_valid;
        if (item_valid && frame_end) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!result_valid || !result_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (cmd.finish) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

endmodule

/* rtl/core/sbfs_dp.sv */
// datapath: config registers, sample statistics, variance divider, burst best tracking
// depends on sbfs_pkg; sequenced by sbfs_ctrl
module sbfs_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sbfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [sbfs_pkg::BYTE_W-1:0]         data_byte,
  input  sbfs_pkg::dp_cmd_t                   cmd,
  output sbfs_pkg::dp_status_t                status,
  output logic [sbfs_pkg::SCORE_W-1:0]        frame_score,
  output logic [sbfs_pkg::IDX_W-1:0]          frame_number,
  output logic [sbfs_pkg::IDX_W-1:0]          best_frame,
  output logic                                burst_done
);
  import sbfs_pkg::*;

  logic [STRIDE_W-1:0]     sample_stride;
  logic [BURST_W-1:0]      burst_length;

  logic [PHASE_W-1:0]      stride_phase;
  logic [BYTE_W-1:0]       previous_byte;
  logic                    first_byte_seen;
  logic signed [SUM_W-1:0] diff_sum;
  logic [SQSUM_W-1:0]      diff_square_sum;
  logic [COUNT_W-1:0]      sample_count;
  logic [IDX_W-1:0]        frame_counter;
  logic [SCORE_W-1:0]      best_score;
  logic [IDX_W-1:0]        best_index;

  logic [PLO_W-1:0]        prod_lo;
  logic [PHI_W-1:0]        prod_hi;
  logic [DIFF_W-1:0]       sum_sq;
  logic [NN_W-1:0]         count_sq;
  logic [REM_W-1:0]        rem;
  logic [SCORE_W-1:0]      quot;
  logic [DIV_CNT_W-1:0]    div_cnt;

  // per-byte sample terms
  logic [STRIDE_W-1:0]     stride_eff;
  logic [STRIDE_W-1:0]     phase_inc;
  logic signed [BYTE_W:0]  diff;
  logic [BYTE_W:0]         diff_neg;
  logic [BYTE_W-1:0]       diff_mag;
  logic [2*BYTE_W-1:0]     diff_sq;
  logic                    take_sample;

  // frame-end terms
  logic [SUM_W-1:0]        sum_neg;
  logic [SUM_MAG_W-1:0]    sum_mag;
  logic [DIFF_W-1:0]       spread;
  logic [REM_W:0]          rem_shift;
  logic [REM_W:0]          rem_sub;
  logic                    rem_ge;
  logic [BURST_W-1:0]      burst_eff;
  logic [SCORE_W-1:0]      score_val;
  logic                    new_best;
  logic [IDX_W-1:0]        best_idx_next;
  logic                    done;

  always_comb begin
    stride_eff = sample_stride;
    if (sample_stride == '0) begin
      stride_eff = STRIDE_W'(1);
    end else if (sample_stride > STRIDE_CAP) begin
      stride_eff = STRIDE_CAP;
    end
    phase_inc   = STRIDE_W'(stride_phase) + STRIDE_W'(1);
    diff        = $signed({1'b0, data_byte}) - $signed({1'b0, previous_byte});
    diff_neg    = 9'(-diff);
    diff_mag    = diff[BYTE_W] ? diff_neg[BYTE_W-1:0] : diff[BYTE_W-1:0];
    diff_sq     = (2*BYTE_W)'(diff_mag) * (2*BYTE_W)'(diff_mag);
    take_sample = first_byte_seen && (stride_phase == '0) && (sample_count < MAX_SAMPLES);
  end

  always_comb begin
    sum_neg   = SUM_W'(-diff_sum);
    sum_mag   = diff_sum[SUM_W-1] ? sum_neg[SUM_MAG_W-1:0] : diff_sum[SUM_MAG_W-1:0];
    // n*sumsq - sum^2, never negative
    spread    = DIFF_W'(prod_lo) + (DIFF_W'(prod_hi) << SQ_LO_W) - sum_sq;
    rem_shift = {rem, quot[SCORE_W-1]};
    rem_ge    = rem_shift >= (REM_W+1)'(count_sq);
    rem_sub   = rem_shift - (REM_W+1)'(count_sq);

    burst_eff = burst_length;
    if (burst_length == '0) begin
      burst_eff = BURST_W'(1);
    end else if (burst_length > MAX_BURST) begin
      burst_eff = MAX_BURST;
    end
    score_val     = (sample_count == '0) ? '0 : quot;
    new_best      = (frame_counter == '0) || (score_val > best_score);
    best_idx_next = new_best ? frame_counter : best_index;
    done          = (BURST_W'(frame_counter) + BURST_W'(1)) >= burst_eff;
    status.div_last = (div_cnt == DIV_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_stride <= STRIDE_RESET;
      burst_length  <= BURST_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SAMPLE_STRIDE: sample_stride <= cfg_data;
        CFG_BURST_LENGTH:  burst_length  <= cfg_data[BURST_W-1:0];
        default: ;
      endcase
    end
  end

  // frame statistics
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      stride_phase    <= '0;
      previous_byte   <= '0;
      first_byte_seen <= 1'b0;
      diff_sum        <= '0;
      diff_square_sum <= '0;
      sample_count    <= '0;
    end else if (cmd.accept) begin
      if (first_byte_seen) begin
        if (take_sample) begin
          diff_sum        <= diff_sum + SUM_W'(diff);
          diff_square_sum <= diff_square_sum + SQSUM_W'(diff_sq);
          sample_count    <= sample_count + COUNT_W'(1);
        end
        stride_phase <= (phase_inc >= stride_eff) ? '0 : phase_inc[PHASE_W-1:0];
      end else begin
        stride_phase <= '0;
      end
      previous_byte   <= data_byte;
      first_byte_seen <= 1'b1;
    end
  end

  // burst tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= '0;
      best_score    <= '0;
      best_index    <= '0;
    end else if (cmd.finish) begin
      if (done) begin
        frame_counter <= '0;
        best_score    <= '0;
        best_index    <= '0;
      end else begin
        frame_counter <= frame_counter + IDX_W'(1);
        if (new_best) begin
          best_score <= score_val;
          best_index <= frame_counter;
        end
      end
    end
  end

  // products, then restoring divide of 256*spread by n^2, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_lo  <= PLO_W'(sample_count) * PLO_W'(diff_square_sum[SQ_LO_W-1:0]);
      prod_hi  <= PHI_W'(sample_count) * PHI_W'(diff_square_sum[SQSUM_W-1:SQ_LO_W]);
      sum_sq   <= DIFF_W'(sum_mag) * DIFF_W'(sum_mag);
      count_sq <= NN_W'(sample_count) * NN_W'(sample_count);
    end
    if (cmd.sub_load) begin
      rem     <= spread[DIFF_W-1:16];
      quot    <= {spread[15:0], 8'd0};
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? rem_sub[REM_W-1:0] : rem_shift[REM_W-1:0];
      quot    <= {quot[SCORE_W-2:0], rem_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      frame_score  <= score_val;
      frame_number <= frame_counter;
      best_frame   <= best_idx_next;
      burst_done   <= done;
    end
  end

endmodule

/* rtl/core/sharpness_best_frame_select_core.sv */
// Takes frame bytes one per cycle. Bytes that do not end a frame are
// accepted back to back, also while a result waits to be taken. The byte
// that ends a frame holds the input channel through ST_MUL and ST_SUB for
// the multiplies and the variance difference, then a restoring divider
// that produces one of the 24 score bits per cycle, then ST_FIN to load
// the result register; the hold grows while the previous result is still
// stalled. The user must write config only while idle; it is unenforced.
// top level; depends on sbfs_pkg, sbfs_ctrl and sbfs_dp
module sharpness_best_frame_select_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sbfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbfs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [sbfs_pkg::BYTE_W-1:0]        data_byte,
  input  logic                               frame_end,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [sbfs_pkg::SCORE_W-1:0]       frame_score,
  output logic [sbfs_pkg::IDX_W-1:0]         frame_number,
  output logic [sbfs_pkg::IDX_W-1:0]         best_frame,
  output logic                               burst_done
);
  import sbfs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sbfs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .frame_end    (frame_end),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  sbfs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .status       (status),
    .frame_score  (frame_score),
    .frame_number (frame_number),
    .best_frame   (best_frame),
    .burst_done   (burst_done)
  );

`ifndef SYNTHESIS
  a_end_holds_input: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && frame_end |=> item_stall)
    else $error("input not held after frame end");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> frame_score <= SCORE_MAX)
    else $error("score above variance bound");

  a_best_not_ahead: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> best_frame <= frame_number)
    else $error("best frame index ahead of current frame");

  a_first_is_best: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_number == '0 |-> best_frame == '0)
    else $error("first frame of burst not taken as best");
`endif

endmodule

/* test/sharpness_best_frame_select_core_tb.sv */
// self-checking testbench for sharpness_best_frame_select_core: directed table, then
// random bursts, checked against the table's typed results or a predictor
// depends on sbfs_pkg and the core rtl
module sharpness_best_frame_select_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 700;
  localparam int MIN_FRAMES = 24;
  localparam int PLAN_LEN = 30;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [IDX_W-1:0]   number;
    logic [IDX_W-1:0]   best;
    logic               done;
  } frame_result_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] value;
    logic                  last;
    logic                  typed;
    frame_result_t         res;
  } plan_row_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum {FILL_RANDOM, FILL_FLAT, FILL_EXTREME, FILL_NEAR} fill_t;

  localparam frame_result_t NO_RES = '0;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // single-byte frame right after reset
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h000, 1'b1, 1'b1, '{24'd0, 4'd0, 4'd0, 1'b0}},
    // one pair only, ties with frame 0 so frame 0 stays best
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h0ff, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h000, 1'b1, 1'b1, '{24'd0, 4'd1, 4'd0, 1'b0}},
    '{ROW_CFG,  CFG_SAMPLE_STRIDE, 13'd1,   1'b0, 1'b0, NO_RES},
    // +255 then -255 gives the largest score
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h000, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h0ff, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h000, 1'b1, 1'b1, '{SCORE_MAX, 4'd2, 4'd2, 1'b0}},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h080, 1'b1, 1'b1, '{24'd0, 4'd3, 4'd2, 1'b1}},
    // zero stride and zero burst length
    '{ROW_CFG,  CFG_SAMPLE_STRIDE, 13'd0,   1'b0, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_BURST_LENGTH,  13'd0,   1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h010, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h020, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h005, 1'b1, 1'b0, NO_RES},
    // both registers above their caps
    '{ROW_CFG,  CFG_SAMPLE_STRIDE, 13'h1fff, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_BURST_LENGTH,  13'd31,  1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h0fe, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h001, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h07f, 1'b1, 1'b0, NO_RES},
    // stride cut from 4 to 2 while the phase sits at 2
    '{ROW_CFG,  CFG_SAMPLE_STRIDE, 13'd4,   1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h001, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h07f, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h033, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_SAMPLE_STRIDE, 13'd2,   1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h044, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h090, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h0aa, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h03c, 1'b1, 1'b0, NO_RES},
    // burst length dropped below the current frame index
    '{ROW_CFG,  CFG_BURST_LENGTH,  13'd1,   1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h000, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_SAMPLE_STRIDE, 13'h0ff, 1'b1, 1'b0, NO_RES}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [BYTE_W-1:0]     data_byte = '0;
  logic                  frame_end = 1'b0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [SCORE_W-1:0]    frame_score;
  logic [IDX_W-1:0]      frame_number;
  logic [IDX_W-1:0]      best_frame;
  logic                  burst_done;

  sharpness_best_frame_select_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .data_byte    (data_byte),
    .frame_end    (frame_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .frame_score  (frame_score),
    .frame_number (frame_number),
    .best_frame   (best_frame),
    .burst_done   (burst_done)
  );

  // predictor state
  logic [STRIDE_W-1:0]      stride_reg = STRIDE_RESET;
  logic [BURST_W-1:0]       burst_reg = BURST_RESET;
  logic [PHASE_W-1:0]       phase_q = '0;
  logic [BYTE_W-1:0]        prev_q = '0;
  logic                     seen_q = 1'b0;
  logic signed [SUM_W-1:0]  sum_q = '0;
  logic [SQSUM_W-1:0]       sq_q = '0;
  logic [COUNT_W-1:0]       n_q = '0;
  logic [IDX_W-1:0]         frame_q = '0;
  logic [SCORE_W-1:0]       best_score_q = '0;
  logic [IDX_W-1:0]         best_idx_q = '0;

  frame_result_t expected_q[$];
  int          fails = 0;
  int unsigned cycles = 0;
  int          burst_left = 0;
  int          frames_sent = 0;
  int          bytes_sent = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // folds one byte into the frame statistics; on frame end works out the score
  task automatic score_byte(input logic [BYTE_W-1:0] b, input logic last,
                            output logic produced, output frame_result_t res);
    int unsigned eff_stride;
    int unsigned blen;
    longint diff;
    longint unsigned n, mag, d, nn;
    logic [SCORE_W-1:0] score;
    eff_stride = (stride_reg == 0) ? 1 : (stride_reg > STRIDE_CAP) ? STRIDE_CAP : stride_reg;
    if (seen_q) begin
      if (phase_q == '0 && n_q < MAX_SAMPLES) begin
        diff = longint'(b) - longint'(prev_q);
        sum_q = sum_q + SUM_W'(diff);
        sq_q = sq_q + SQSUM_W'(diff * diff);
        n_q = n_q + 1'b1;
      end
      phase_q = (phase_q + 1 >= eff_stride) ? '0 : phase_q + 1'b1;
    end else begin
      phase_q = '0;
    end
    prev_q = b;
    seen_q = 1'b1;
    produced = last;
    res = '0;
    if (last) begin
      n = n_q;
      if (n == 0) begin
        score = '0;
      end else begin
        mag = (sum_q < 0) ? -sum_q : sum_q;
        d = n * sq_q - mag * mag;
        nn = n * n;
        score = SCORE_W'((d / nn) * 256 + ((d % nn) * 256) / nn);
      end
      blen = (burst_reg == 0) ? 1 : (burst_reg > MAX_BURST) ? MAX_BURST : burst_reg;
      if (frame_q == 0 || score > best_score_q) begin
        best_score_q = score;
        best_idx_q = frame_q;
      end
      res.score = score;
      res.number = frame_q;
      res.best = best_idx_q;
      res.done = (frame_q + 1 >= blen);
      if (res.done) begin
        frame_q = '0;
        best_score_q = '0;
        best_idx_q = '0;
      end else begin
        frame_q = frame_q + 1'b1;
      end
      phase_q = '0;
      prev_q = '0;
      seen_q = 1'b0;
      sum_q = '0;
      sq_q = '0;
      n_q = '0;
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                           input logic typed, input frame_result_t typed_res);
    int gap;
    logic produced;
    frame_result_t res;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        item_valid <= 1'b0;
        data_byte <= BYTE_W'($urandom);
        frame_end <= 1'($urandom);
      end
    end
    @(negedge clk);
    item_valid <= 1'b1;
    data_byte <= b;
    frame_end <= last;
    do @(posedge clk); while (item_stall);
    score_byte(b, last, produced, res);
    if (produced) begin
      expected_q.push_back(typed ? typed_res : res);
      frames_sent++;
    end
    bytes_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // no request in flight and no score still being computed
  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (sel == CFG_SAMPLE_STRIDE) stride_reg = value;
    else burst_reg = BURST_W'(value);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte(fill_t fill, logic [BYTE_W-1:0] base);
    case (fill)
      FILL_FLAT:    return base;
      FILL_EXTREME: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      FILL_NEAR:    return base + BYTE_W'($urandom_range(0, 6)) - 8'd3;
      default:      return BYTE_W'($urandom);
    endcase
  endfunction

  initial begin
    int bytes_mark, frames_mark, n_frames, frame_len, r;
    logic cut;
    fill_t fill;
    logic [BYTE_W-1:0] base;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(PLAN[i].reg_sel, PLAN[i].value);
      end else begin
        send_byte(PLAN[i].value[BYTE_W-1:0], PLAN[i].last, PLAN[i].typed, PLAN[i].res);
      end
    end

    bytes_mark = bytes_sent;
    frames_mark = frames_sent;
    while (bytes_sent - bytes_mark < RANDOM_ITEMS || frames_sent - frames_mark < MIN_FRAMES) begin
      wait_idle();
      r = $urandom_range(0, 2);
      if (r != 1) begin
        case ($urandom_range(0, 9))
          0:       write_reg(CFG_SAMPLE_STRIDE, 13'd0);
          1:       write_reg(CFG_SAMPLE_STRIDE, 13'd1);
          2:       write_reg(CFG_SAMPLE_STRIDE, 13'd2);
          3:       write_reg(CFG_SAMPLE_STRIDE, 13'd3);
          4:       write_reg(CFG_SAMPLE_STRIDE, CFG_DATA_W'($urandom_range(4, 16)));
          5:       write_reg(CFG_SAMPLE_STRIDE, STRIDE_RESET);
          6:       write_reg(CFG_SAMPLE_STRIDE, STRIDE_CAP);
          7:       write_reg(CFG_SAMPLE_STRIDE, CFG_DATA_W'($urandom_range(4097, 8191)));
          default: write_reg(CFG_SAMPLE_STRIDE, CFG_DATA_W'($urandom_range(1, 8)));
        endcase
      end
      if (r != 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(CFG_BURST_LENGTH, CFG_DATA_W'($urandom_range(0, 31)));
          1:       write_reg(CFG_BURST_LENGTH, CFG_DATA_W'(MAX_BURST));
          2:       write_reg(CFG_BURST_LENGTH, 13'd1);
          default: write_reg(CFG_BURST_LENGTH, CFG_DATA_W'($urandom_range(2, 6)));
        endcase
      end
      n_frames = $urandom_range(1, 10);
      for (int f = 0; f < n_frames; f++) begin
        r = $urandom_range(0, 9);
        frame_len = (r < 7) ? $urandom_range(1, 8) :
                    (r < 9) ? $urandom_range(9, 40) : $urandom_range(41, 300);
        fill = fill_t'($urandom_range(0, 3));
        base = BYTE_W'($urandom);
        // sometimes leave the frame open so the next settings land mid-frame
        cut = (f == n_frames - 1) && ($urandom_range(0, 3) == 0);
        for (int k = 0; k < frame_len; k++)
          send_byte(pick_byte(fill, base), (k == frame_len - 1) && !cut, 1'b0, NO_RES);
      end
    end
    send_byte(BYTE_W'($urandom), 1'b1, 1'b0, NO_RES);
    wait_idle();

    if (fails == 0 && expected_q.size() == 0) begin
      $display("** sharpness_best_frame_select_core: PASSED **");
    end else begin
      $display("** sharpness_best_frame_select_core: FAILED **");
    end
    $finish;
  end

  // receiver stall pattern, switching modes every so often
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
      default:     result_stall <= (cycles % 9) < 4;
    endcase
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: frame_score %0d frame_number %0d", frame_score, frame_number);
        fails++;
      end else begin
        want = expected_q.pop_front();
        if (frame_score !== want.score) begin
          $error("frame_score: expected %0d, got %0d", want.score, frame_score);
          fails++;
        end
        if (frame_number !== want.number) begin
          $error("frame_number: expected %0d, got %0d", want.number, frame_number);
          fails++;
        end
        if (best_frame !== want.best) begin
          $error("best_frame: expected %0d, got %0d", want.best, best_frame);
          fails++;
        end
        if (burst_done !== want.done) begin
          $error("burst_done: expected %0d, got %0d", want.done, burst_done);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** sharpness_best_frame_select_core: FAILED **");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/core/sbfs_pkg.sv
rtl/core/sbfs_ctrl.sv
rtl/core/sbfs_dp.sv
rtl/core/sharpness_best_frame_select_core.sv
test/sharpness_best_frame_select_core_tb.sv
